// ===== sv/swam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and defaults for the scroll window address mapper.
// No dependencies; used by swam_mod_unit and scroll_window_address_mapper_top.

package swam_pkg;

    localparam int ROW_W = 9;   // screen row / column / config width
    localparam int ADR_W = 10;  // frame memory address and window size width
    localparam int IDX_W = 2;   // configuration index width

    localparam int DEF_SCREEN_ROWS = 320;
    localparam int DEF_MEMORY_ROWS = 480;
    localparam int DEF_CELL_ROWS   = 10;

    // command codes
    localparam logic [1:0] CMD_WINDOW    = 2'd0;
    localparam logic [1:0] CMD_SCROLL_UP = 2'd1;
    localparam logic [1:0] CMD_SCROLL_DN = 2'd2;
    localparam logic [1:0] CMD_SCROLL_RS = 2'd3;

    // result kinds
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TOP_FIXED = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOT_FIXED = 2'd1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ROW_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [ADR_W-1:0] win_width;
        logic [ADR_W-1:0] win_height;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [ADR_W-1:0] col_first;
        logic [ADR_W-1:0] row_first;
        logic [ADR_W-1:0] col_last;
        logic [ADR_W-1:0] row_last;
        logic [ADR_W-1:0] scroll_start;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/swam_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on swam_pkg for the operand width.

module swam_mod_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [swam_pkg::ADR_W-1:0]  i_dividend,
    input  wire logic [swam_pkg::ADR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [swam_pkg::ADR_W-1:0]       o_rem
);
    import swam_pkg::*;

    localparam int CNT_W = $clog2(ADR_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADR_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ADR_W-1:0] r_rem;
    logic [ADR_W-1:0] r_dvd;
    logic [ADR_W-1:0] r_div;
    logic [ADR_W:0]   w_trial;
    logic [ADR_W:0]   w_diff;
    logic [ADR_W-1:0] n_rem;

    // shift in the next dividend bit, subtract where it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[ADR_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[ADR_W-1:0];
        end else begin
            n_rem = w_trial[ADR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ADR_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");

endmodule

`default_nettype wire

// ===== sv/scroll_window_address_mapper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Scroll window address mapper, top level.
// Depends on swam_pkg and swam_mod_unit.
//
// Use:
//   Input channel (i_in_valid / o_in_ready, payload i_in_data) carries window
//   requests and scroll commands. Output channel (o_out_valid / i_out_ready,
//   payload o_out_data) returns at most one result per command. The
//   configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
//   i_cfg_data) sets the top and bottom fixed areas; it is always ready, and
//   any write to either register clears the scroll offset. Write it only
//   while the block is idle.
// Sequencing:
//   One command at a time. A window inside the scroll band goes through
//   dispatch, one pass of the shared remainder unit and finish; a window
//   outside the band or a scroll reset goes from dispatch to finish. Scroll
//   up / down make two passes through the remainder unit, one for the cell
//   step modulo the memory height and one for the new offset. The input is
//   ready again the cycle after the result is loaded. The remainder unit
//   works bit-serially over 10 bits.
// Reset clears fixed areas, offset and the output valid flag. When the
//   receiver stalls, the finished result waits in the output register;
//   the next command is still taken and waits in its final state until the
//   output register frees up.

module scroll_window_address_mapper_top #(
    parameter int SCREEN_ROWS = swam_pkg::DEF_SCREEN_ROWS,
    parameter int MEMORY_ROWS = swam_pkg::DEF_MEMORY_ROWS,
    parameter int CELL_ROWS   = swam_pkg::DEF_CELL_ROWS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire swam_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output swam_pkg::t_out_item              o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [swam_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [swam_pkg::ROW_W-1:0]  i_cfg_data
);
    import swam_pkg::*;

    localparam int GW = ADR_W + 1;
    localparam logic [GW-1:0]    SCR_G  = GW'(SCREEN_ROWS);
    localparam logic [GW-1:0]    MEM_G  = GW'(MEMORY_ROWS);
    localparam logic [ADR_W-1:0] CELL_A = ADR_W'(CELL_ROWS);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_WMOD = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_SMOD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       r_state, n_state;
    t_in_item         r_item;
    logic [ROW_W-1:0] r_top_cfg;
    logic [ROW_W-1:0] r_bot_cfg;
    logic [ROW_W-1:0] r_offset, n_offset;
    t_out_item        r_res, n_res;
    t_out_item        r_out;
    logic             r_out_valid;

    // band geometry
    logic [GW-1:0]    w_sum;
    logic             w_zero_areas;
    logic [ROW_W-1:0] w_top;
    logic [ROW_W-1:0] w_bot;
    logic [GW-1:0]    w_eff_sum;
    logic [GW-1:0]    w_mem_g;
    logic [ADR_W-1:0] w_mem;
    logic             w_in_band;

    // remainder unit hookup
    logic             w_mod_start;
    logic [ADR_W-1:0] w_mod_dvd;
    logic             w_mod_done;
    logic [ADR_W-1:0] w_mod_rem;

    // window end arithmetic
    logic [GW-1:0]    w_rf;
    logic [GW:0]      w_rf_h;
    logic [GW:0]      w_rl_raw;
    logic [GW:0]      w_limit;
    logic [GW:0]      w_rl;
    logic             w_out_free;
    logic             w_cfg_hit;

    // Drop both fixed areas when they leave no band on screen or one taller than the memory.
    always_comb begin
        w_sum        = GW'(r_top_cfg) + GW'(r_bot_cfg);
        w_zero_areas = (w_sum >= SCR_G) || ((SCR_G - w_sum) > MEM_G);
        w_top        = w_zero_areas ? '0 : r_top_cfg;
        w_bot        = w_zero_areas ? '0 : r_bot_cfg;
        w_eff_sum    = w_zero_areas ? '0 : w_sum;
        w_mem_g      = (w_eff_sum >= MEM_G) ? '0 : (MEM_G - w_eff_sum);
        w_mem        = w_mem_g[ADR_W-1:0];
        w_in_band    = (w_mem != '0) && (r_item.row >= w_top)
                     && ((GW'(r_item.row) + GW'(w_bot)) < SCR_G);
    end

    // Mapped window rows: start below the top area, end clamped to the band.
    always_comb begin
        w_rf     = GW'(w_top) + GW'(w_mod_rem);
        w_rf_h   = (GW+1)'(w_rf) + (GW+1)'(r_item.win_height);
        w_rl_raw = w_rf_h - 1'b1;
        w_limit  = (GW+1)'(w_top) + (GW+1)'(w_mem) - 1'b1;
        if ((w_rf_h == '0) || (w_rl_raw > w_limit)) begin
            w_rl = w_limit;
        end else begin
            w_rl = w_rl_raw;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_offset    = r_offset;
        n_res       = r_res;
        w_mod_start = 1'b0;
        w_mod_dvd   = ADR_W'(r_offset) + ADR_W'(r_item.row);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res = '0;
                case (r_item.cmd)
                    CMD_WINDOW: begin
                        n_res.kind      = KIND_WINDOW;
                        n_res.col_first = ADR_W'(r_item.col);
                        n_res.col_last  = ADR_W'(r_item.col) + r_item.win_width - 1'b1;
                        if (w_in_band) begin
                            w_mod_start = 1'b1;
                            n_state     = S_WMOD;
                        end else begin
                            n_res.row_first = ADR_W'(r_item.row);
                            n_res.row_last  = ADR_W'(r_item.row) + r_item.win_height
                                            - 1'b1;
                            n_state         = S_FIN;
                        end
                    end
                    CMD_SCROLL_UP, CMD_SCROLL_DN: begin
                        if (w_mem == '0) begin
                            n_state = S_IDLE;   // no band, no result
                        end else begin
                            w_mod_start = 1'b1;
                            w_mod_dvd   = CELL_A;
                            n_state     = S_STEP;
                        end
                    end
                    default: begin
                        // scroll reset
                        n_offset           = '0;
                        n_res.kind         = KIND_SCROLL;
                        n_res.scroll_start = ADR_W'(w_top);
                        n_state            = S_FIN;
                    end
                endcase
            end
            S_WMOD: begin
                if (w_mod_done) begin
                    n_res.row_first = w_rf[ADR_W-1:0];
                    n_res.row_last  = w_rl[ADR_W-1:0];
                    n_state         = S_FIN;
                end
            end
            S_STEP: begin
                // offset stays below the memory height, so one more pass wraps it
                if (w_mod_done) begin
                    w_mod_start = 1'b1;
                    if (r_item.cmd == CMD_SCROLL_UP) begin
                        w_mod_dvd = ADR_W'(r_offset) + w_mod_rem;
                    end else begin
                        w_mod_dvd = ADR_W'(r_offset) + w_mem - w_mod_rem;
                    end
                    n_state = S_SMOD;
                end
            end
            S_SMOD: begin
                if (w_mod_done) begin
                    n_offset           = w_mod_rem[ROW_W-1:0];
                    n_res.kind         = KIND_SCROLL;
                    n_res.scroll_start = ADR_W'(w_top) + ADR_W'(w_mod_rem[ROW_W-1:0]);
                    n_state            = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cfg_hit = i_cfg_valid
                     && ((i_cfg_index == REG_TOP_FIXED) || (i_cfg_index == REG_BOT_FIXED));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= '0;
            r_top_cfg   <= '0;
            r_bot_cfg   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_offset <= n_offset;
            // hold the result until the receiver takes it
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && (i_cfg_index == REG_TOP_FIXED)) begin
                r_top_cfg <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == REG_BOT_FIXED)) begin
                r_bot_cfg <= i_cfg_data;
            end
            if (w_cfg_hit) begin
                r_offset <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_item <= i_in_data;
        end
        r_res <= n_res;
        if ((r_state == S_FIN) && w_out_free) begin
            r_out <= r_res;
        end
    end

    swam_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_mem),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_offset_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem != '0) |-> (ADR_W'(r_offset) < w_mem))
        else $error("scroll offset outside memory band");
    a_mod_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |-> ((r_state == S_DISP) || (r_state == S_STEP)))
        else $error("remainder unit started from wrong state");
    a_scroll_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_SCROLL)) |->
        ((r_out.col_first == '0) && (r_out.row_last == '0)))
        else $error("scroll result carries window fields");
    a_window_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_WINDOW)) |-> (r_out.scroll_start == '0))
        else $error("window result carries scroll start");

endmodule

`default_nettype wire

// ===== bench/swam_addr_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the scroll window address mapper: watches the command, result
// and configuration channels, predicts every result and compares it.
// Depends on swam_pkg for the item types, command codes and register indexes.

module swam_addr_checker #(
    parameter int SCREEN_ROWS = swam_pkg::DEF_SCREEN_ROWS,
    parameter int MEMORY_ROWS = swam_pkg::DEF_MEMORY_ROWS,
    parameter int CELL_ROWS   = swam_pkg::DEF_CELL_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  swam_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  swam_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [swam_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [swam_pkg::ROW_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import swam_pkg::*;

    logic [ROW_W-1:0] top_rows   = '0;
    logic [ROW_W-1:0] bot_rows   = '0;
    logic [ROW_W-1:0] scroll_ofs = '0;
    t_out_item        expected_addr_q[$];
    int               n_mismatch = 0;
    int               n_checked  = 0;

    // Work out the result of one command and advance the scroll offset.
    function automatic bit map_command(input t_in_item req, output t_out_item res);
        int unsigned top_e, bot_e, fixed_sum, mem, row, hgt, yv, lim, rf, rl, ofs, cell_step;
        res = '0;
        top_e     = top_rows;
        bot_e     = bot_rows;
        fixed_sum = top_e + bot_e;
        // no scroll area left on screen, or more than the memory holds: drop both fixed areas
        if (fixed_sum >= SCREEN_ROWS || SCREEN_ROWS - fixed_sum > MEMORY_ROWS) begin
            top_e     = 0;
            bot_e     = 0;
            fixed_sum = 0;
        end
        mem = (fixed_sum >= MEMORY_ROWS) ? 0 : MEMORY_ROWS - fixed_sum;

        case (req.cmd)
            CMD_WINDOW: begin
                row = req.row;
                hgt = req.win_height;
                if (mem != 0 && row >= top_e && row + bot_e < SCREEN_ROWS) begin
                    yv  = (scroll_ofs + row) % mem;
                    lim = top_e + mem - 1;
                    rf  = top_e + yv;
                    if (rf + hgt == 0) begin
                        rl = lim;
                    end else begin
                        rl = rf + hgt - 1;
                        if (rl > lim)
                            rl = lim;
                    end
                end else begin
                    rf = row;
                    rl = row + hgt - 1;
                end
                res.kind      = KIND_WINDOW;
                res.col_first = 10'(req.col);
                res.row_first = 10'(rf);
                res.col_last  = 10'(req.col + req.win_width - 1);
                res.row_last  = 10'(rl);
                return 1'b1;
            end
            CMD_SCROLL_UP, CMD_SCROLL_DN: begin
                if (mem == 0)
                    return 1'b0;
                ofs       = scroll_ofs % mem;
                cell_step = CELL_ROWS % mem;
                if (req.cmd == CMD_SCROLL_UP)
                    ofs = (ofs + cell_step) % mem;
                else
                    ofs = (ofs + mem - cell_step) % mem;
                scroll_ofs = 9'(ofs);
            end
            default: scroll_ofs = '0;
        endcase
        res.kind         = KIND_SCROLL;
        res.scroll_start = 10'(top_e + scroll_ofs);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_mismatch++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            top_rows   = '0;
            bot_rows   = '0;
            scroll_ofs = '0;
            expected_addr_q.delete();
        end else begin
            // results first: a result can never belong to a command taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_addr_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, i_out_data);
                    n_mismatch++;
                end else begin
                    want = expected_addr_q.pop_front();
                    check_field("kind", 10'(want.kind), 10'(i_out_data.kind));
                    check_field("col_first", want.col_first, i_out_data.col_first);
                    check_field("row_first", want.row_first, i_out_data.row_first);
                    check_field("col_last", want.col_last, i_out_data.col_last);
                    check_field("row_last", want.row_last, i_out_data.row_last);
                    check_field("scroll_start", want.scroll_start, i_out_data.scroll_start);
                    n_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TOP_FIXED: begin
                        top_rows   = i_cfg_data;
                        scroll_ofs = '0;
                    end
                    REG_BOT_FIXED: begin
                        bot_rows   = i_cfg_data;
                        scroll_ofs = '0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (map_command(i_in_data, res))
                    expected_addr_q.push_back(res);
            end
        end
        o_fail_count <= n_mismatch;
        o_pending    <= expected_addr_q.size();
        o_checked    <= n_checked;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the scroll window address mapper bench: clock, reset, stimulus,
// handshake pacing and verdict. Depends on swam_pkg, swam_addr_checker and
// scroll_window_address_mapper_top.

module tb;
    import swam_pkg::*;

    localparam int RUN_LIMIT      = 500000;  // cycles before the run is declared hung
    localparam int N_SETTINGS     = 8;
    localparam int RAND_PER_PHASE = 166;
    localparam int SETTLE_CYCLES  = 40;      // beyond the longest command

    // Fixed-area settings: reset values, an ordinary band, single-row bands at
    // both ends, sums that leave no scroll area (both zeroed), and the extremes.
    localparam int TOP_SET[N_SETTINGS] = '{0, 40, 0, 319, 511, 160, 1, 200};
    localparam int BOT_SET[N_SETTINGS] = '{0, 20, 319, 0, 511, 160, 0, 100};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    t_out_item            out_data;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct  = 0;   // chance in a hundred that the sender idles a cycle
    int rx_stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int rx_hold_req  = 0;   // length of a requested receiver hold-off
    int n_sent       = 0;
    int cycle_count  = 0;

    scroll_window_address_mapper_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    swam_addr_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver pacing. A hold-off request is counted down here, one cycle at a
    // time, so that it runs regardless of what the sender is doing.
    initial begin : rx_pacing
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic t_in_item mk(input logic [1:0] c, input int col, input int row,
                                    input int w, input int h);
        t_in_item it;
        it.cmd        = c;
        it.col        = 9'(col);
        it.row        = 9'(row);
        it.win_width  = 10'(w);
        it.win_height = 10'(h);
        return it;
    endfunction

    // Window sizes: mostly text-cell sized, sometimes up to the full field,
    // with zero and the largest code thrown in.
    function automatic logic [9:0] rand_size(input int typical);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 10'($urandom_range(typical, 1));
        else if (sel < 80)
            return 10'($urandom_range(512, 1));
        else if (sel < 90)
            return 10'($urandom);
        else if (sel < 95)
            return 10'd0;
        return 10'h3ff;
    endfunction

    function automatic t_in_item rand_cmd();
        t_in_item    it;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 68)
            it.cmd = CMD_WINDOW;
        else if (sel < 81)
            it.cmd = CMD_SCROLL_UP;
        else if (sel < 95)
            it.cmd = CMD_SCROLL_DN;
        else
            it.cmd = CMD_SCROLL_RS;
        it.col = 9'($urandom);
        // rows: mostly on screen, often at the band edges, sometimes anywhere
        sel = $urandom_range(99);
        if (sel < 60)
            it.row = 9'($urandom_range(DEF_SCREEN_ROWS - 1));
        else if (sel < 70)
            it.row = 9'(DEF_SCREEN_ROWS - 1 - $urandom_range(1));
        else if (sel < 78)
            it.row = 9'($urandom_range(1));
        else
            it.row = 9'($urandom);
        it.win_width  = rand_size(64);
        it.win_height = rand_size(40);
        return it;
    endfunction

    // Offer one command and hold it until the transfer; valid is left high so
    // that back-to-back commands never lower and raise it in the same step.
    task automatic send_cmd(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        n_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Reprogram both fixed areas with the block idle.
    task automatic set_fixed_rows(input int top, input int bot);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TOP_FIXED;
        cfg_data  <= 9'(top);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_BOT_FIXED;
        cfg_data  <= 9'(bot);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        t_in_item directed[$];
        int       phase;
        int       n;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands on the reset geometry (no fixed areas, 480-row band).
        directed.push_back(mk(CMD_WINDOW, 0, 0, 1, 1));
        // pass through: row below the screen, widest and tallest codes
        directed.push_back(mk(CMD_WINDOW, 511, 511, 1023, 1023));
        // zero height at mapped row zero: clamp to the bottom of the band
        directed.push_back(mk(CMD_WINDOW, 0, 0, 0, 0));
        directed.push_back(mk(CMD_WINDOW, 100, 319, 8, 512));
        directed.push_back(mk(CMD_WINDOW, 5, 320, 10, 10));
        // scroll down from zero wraps to the far end of the band
        directed.push_back(mk(CMD_SCROLL_DN, 511, 511, 1023, 1023));
        directed.push_back(mk(CMD_WINDOW, 8, 100, 8, 10));
        directed.push_back(mk(CMD_WINDOW, 16, 9, 8, 1));
        directed.push_back(mk(CMD_WINDOW, 16, 10, 8, 1023));
        directed.push_back(mk(CMD_SCROLL_UP, 0, 0, 0, 0));
        directed.push_back(mk(CMD_SCROLL_UP, 0, 0, 0, 0));
        directed.push_back(mk(CMD_WINDOW, 256, 319, 512, 1023));
        directed.push_back(mk(CMD_SCROLL_RS, 511, 511, 1023, 1023));
        directed.push_back(mk(CMD_SCROLL_DN, 0, 0, 1, 1));
        directed.push_back(mk(CMD_SCROLL_DN, 0, 0, 1, 1));
        directed.push_back(mk(CMD_WINDOW, 511, 0, 512, 0));
        directed.push_back(mk(CMD_WINDOW, 0, 470, 0, 1));
        directed.push_back(mk(CMD_SCROLL_RS, 0, 0, 0, 0));
        directed.push_back(mk(CMD_WINDOW, 0, 0, 0, 0));
        directed.push_back(mk(CMD_WINDOW, 511, 318, 1, 2));
        foreach (directed[i])
            send_cmd(directed[i]);

        // Random commands under each fixed-area setting, rotating the pacing:
        // free-running, sparse sender, stalling receiver, light jitter on both.
        for (phase = 0; phase < N_SETTINGS; phase++) begin
            set_fixed_rows(TOP_SET[phase], BOT_SET[phase]);
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                // long receiver hold-off while commands keep coming: fill the
                // output register and the pending command so the input stalls
                if (phase == 2 && n == 40)
                    rx_hold_req = 400;
                // sender pause until everything has come back
                if (phase == 5 && n == 80)
                    drain();
                send_cmd(rand_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d commands and %0d checked results over %0d fixed-area settings,",
                 n_sent, checked, N_SETTINGS + 1);
        $display("including zeroed and single-row bands, four pacing modes and a long hold-off.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
